### design/koa_pkg.sv
package koa_pkg;

    localparam logic [1:0] CMD_INGEST = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_ADDED      = 3'd0;
    localparam logic [2:0] ST_UPDATED    = 3'd1;
    localparam logic [2:0] ST_NOT_STORED = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_FOUND      = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
    localparam logic [2:0] ST_LISTED     = 3'd6;
    localparam logic [2:0] ST_NONE       = 3'd7;

    localparam logic [13:0] HQ_LEVEL_RESET = 14'd8500;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] target_key;
        logic [31:0] product_key;
        logic [13:0] quality;
        logic [15:0] score;
        logic [19:0] energy;
        logic        is_stored;
        logic [13:0] list_threshold;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic        last;
        logic [31:0] entry_target;
        logic [13:0] peak_quality;
        logic [31:0] total_score;
        logic [39:0] total_energy;
        logic [31:0] obs_count;
        logic        high_flag;
        logic [31:0] latest_product;
        logic [6:0]  entry_total;
    } t_out;

endpackage

### design/koa_front.sv
// Accepts commands, drops unused codes, holds a two-deep queue for the engine.
module koa_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  koa_pkg::t_in   i_data,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output koa_pkg::t_in   o_q_data
);
    koa_pkg::t_in r_q [2];
    logic [1:0]   r_cnt;
    logic         r_wp;
    logic         r_rp;
    logic         w_acc;
    logic         w_push;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_acc     = i_valid && !o_stall;
    assign w_push    = w_acc && (i_data.cmd != koa_pkg::CMD_UNUSED);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    property p_pop_nonempty;
        @(posedge i_clk) disable iff (!i_rst_n) i_q_pop |-> (r_cnt != 2'd0);
    endproperty
    a_pop_nonempty: assert property (p_pop_nonempty) else $error("pop of empty queue");
    property p_no_over;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2;
    endproperty
    a_no_over: assert property (p_no_over) else $error("queue overflow");
    property p_stall_full;
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd2) |-> o_stall;
    endproperty
    a_stall_full: assert property (p_stall_full) else $error("no stall when full");
endmodule

### design/koa_engine.sv
// Scans the table one entry at a time through S_READ and S_CHECK; updates and emits through an output register.
module koa_engine #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [13:0]    i_hq_level,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  koa_pkg::t_in   i_q_data,
    output logic           o_valid,
    input  logic           i_stall,
    output koa_pkg::t_out  o_data
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [31:0]  m_key    [TABLE_DEPTH];
    logic [13:0]  m_best   [TABLE_DEPTH];
    logic [31:0]  m_score  [TABLE_DEPTH];
    logic [39:0]  m_energy [TABLE_DEPTH];
    logic [31:0]  m_count  [TABLE_DEPTH];
    logic         m_flag   [TABLE_DEPTH];
    logic [31:0]  m_latest [TABLE_DEPTH];

    logic [2:0]   r_state;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_hit_idx;
    logic         r_found_any;
    koa_pkg::t_in r_cmd;
    logic [31:0]  r_rkey, r_rscore, r_rcount, r_rlatest;
    logic [13:0]  r_rbest;
    logic [39:0]  r_renergy;
    logic         r_rflag;
    logic [AW-1:0] r_ridx;
    logic         r_pend;
    koa_pkg::t_out r_pend_data;
    logic         r_out_valid;
    koa_pkg::t_out r_out;

    logic [AW-1:0] w_addr;
    logic          w_out_free;
    logic [32:0]   w_score_sum;
    logic [40:0]   w_energy_sum;
    logic [13:0]   w_new_best;
    logic          w_match;
    logic          w_last_idx;

    assign w_addr     = r_idx[AW-1:0];
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign w_last_idx = (({1'b0, r_ridx} + 1'b1) == {1'b0, r_used[AW-1:0]})
                        || (r_used == CW'(TABLE_DEPTH) && r_ridx == AW'(TABLE_DEPTH - 1));

    assign w_match = (r_cmd.cmd == koa_pkg::CMD_LIST) ? (r_rbest >= r_cmd.list_threshold)
                                                      : (r_rkey == r_cmd.target_key);
    assign w_score_sum  = {1'b0, r_rscore} + {17'd0, r_cmd.score};
    assign w_energy_sum = {1'b0, r_renergy} + {21'd0, r_cmd.energy};
    assign w_new_best   = (r_cmd.quality > r_rbest) ? r_cmd.quality : r_rbest;

    function automatic koa_pkg::t_out empty_res(input logic [2:0] st, input logic [6:0] tot);
        koa_pkg::t_out r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        r.entry_total = tot;
        return r;
    endfunction

    logic [6:0] w_tot;
    assign w_tot = 7'(r_used);

    // entry read, registered
    always_ff @(posedge i_clk) begin
        r_rkey    <= m_key[w_addr];
        r_rbest   <= m_best[w_addr];
        r_rscore  <= m_score[w_addr];
        r_renergy <= m_energy[w_addr];
        r_rcount  <= m_count[w_addr];
        r_rflag   <= m_flag[w_addr];
        r_rlatest <= m_latest[w_addr];
        r_ridx    <= w_addr;
    end

    logic          w_wr;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_score, w_wr_count;
    logic [39:0]   w_wr_energy;
    logic [13:0]   w_wr_best;
    logic          w_load;

    always_comb begin
        w_wr        = (r_state == S_WRITE) && (r_cmd.cmd == koa_pkg::CMD_INGEST)
                      && (r_found_any || r_used != CW'(TABLE_DEPTH)) && w_out_free;
        w_wr_addr   = r_found_any ? r_hit_idx : r_used[AW-1:0];
        if (r_found_any) begin
            w_wr_best   = w_new_best;
            w_wr_score  = w_score_sum[32] ? 32'hFFFF_FFFF : w_score_sum[31:0];
            w_wr_energy = w_energy_sum[40] ? 40'hFF_FFFF_FFFF : w_energy_sum[39:0];
            w_wr_count  = (r_rcount == 32'hFFFF_FFFF) ? r_rcount : r_rcount + 32'd1;
        end else begin
            w_wr_best   = r_cmd.quality;
            w_wr_score  = {16'd0, r_cmd.score};
            w_wr_energy = {20'd0, r_cmd.energy};
            w_wr_count  = 32'd1;
        end
    end

    // cycles in which the output register takes a new beat
    assign w_load = (r_state == S_CHECK && r_cmd.cmd == koa_pkg::CMD_LIST && w_match
                     && r_pend && w_out_free)
                    || w_wr
                    || (r_state == S_EMIT && w_out_free);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            m_key[w_wr_addr]    <= r_cmd.target_key;
            m_best[w_wr_addr]   <= w_wr_best;
            m_score[w_wr_addr]  <= w_wr_score;
            m_energy[w_wr_addr] <= w_wr_energy;
            m_count[w_wr_addr]  <= w_wr_count;
            m_flag[w_wr_addr]   <= (w_wr_best >= i_hq_level);
            m_latest[w_wr_addr] <= r_cmd.product_key;
        end
    end

    koa_pkg::t_out w_ent;
    always_comb begin
        w_ent.status         = koa_pkg::ST_LISTED;
        w_ent.last           = 1'b0;
        w_ent.entry_target   = r_rkey;
        w_ent.peak_quality   = r_rbest;
        w_ent.total_score    = r_rscore;
        w_ent.total_energy   = r_renergy;
        w_ent.obs_count      = r_rcount;
        w_ent.high_flag      = r_rflag;
        w_ent.latest_product = r_rlatest;
        w_ent.entry_total    = w_tot;
    end

    koa_pkg::t_out w_find_res;
    always_comb begin
        if (r_found_any) begin
            w_find_res        = w_ent;
            w_find_res.status = koa_pkg::ST_FOUND;
            w_find_res.last   = 1'b1;
        end else begin
            w_find_res = empty_res(koa_pkg::ST_NOT_FOUND, w_tot);
        end
    end

    // S_READ issues address r_idx; S_CHECK sees its data. List holds one match
    // pending until the next one (or the end) tells whether it is last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_found_any <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd       <= i_q_data;
                        r_idx       <= '0;
                        r_found_any <= 1'b0;
                        if (i_q_data.cmd == koa_pkg::CMD_INGEST && !i_q_data.is_stored) begin
                            r_pend_data <= empty_res(koa_pkg::ST_NOT_STORED, w_tot);
                            r_pend      <= 1'b1;
                            r_state     <= S_EMIT;
                        end else if (r_used == '0) begin
                            r_pend  <= 1'b0;
                            r_state <= S_WRITE;
                        end else begin
                            r_pend  <= 1'b0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_cmd.cmd == koa_pkg::CMD_LIST) begin
                        if (w_match) begin
                            if (r_pend) begin
                                if (w_out_free) begin
                                    r_out       <= r_pend_data;
                                    r_pend_data <= w_ent;
                                end
                            end else begin
                                r_pend_data <= w_ent;
                                r_pend      <= 1'b1;
                            end
                        end
                        if (!(w_match && r_pend && !w_out_free)) begin
                            if (w_last_idx) begin
                                r_state <= S_WRITE;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= S_READ;
                            end
                        end
                    end else if (w_match) begin
                        r_found_any <= 1'b1;
                        r_hit_idx   <= r_ridx;
                        r_state     <= S_WRITE;
                    end else if (w_last_idx) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_WRITE: begin
                    // resolve outcome; r_r* still hold the hit entry
                    if (r_cmd.cmd == koa_pkg::CMD_LIST) begin
                        if (r_pend) begin
                            r_pend_data.last <= 1'b1;
                        end else begin
                            r_pend_data <= empty_res(koa_pkg::ST_NONE, w_tot);
                            r_pend      <= 1'b1;
                        end
                        r_state <= S_EMIT;
                    end else if (r_cmd.cmd == koa_pkg::CMD_FIND) begin
                        r_pend_data <= w_find_res;
                        r_pend      <= 1'b1;
                        r_state     <= S_EMIT;
                    end else if (!r_found_any && r_used == CW'(TABLE_DEPTH)) begin
                        r_pend_data <= empty_res(koa_pkg::ST_FULL, w_tot);
                        r_pend      <= 1'b1;
                        r_state     <= S_EMIT;
                    end else if (w_wr) begin
                        r_out.status         <= r_found_any ? koa_pkg::ST_UPDATED
                                                            : koa_pkg::ST_ADDED;
                        r_out.last           <= 1'b1;
                        r_out.entry_target   <= r_cmd.target_key;
                        r_out.peak_quality   <= w_wr_best;
                        r_out.total_score    <= w_wr_score;
                        r_out.total_energy   <= w_wr_energy;
                        r_out.obs_count      <= w_wr_count;
                        r_out.high_flag      <= (w_wr_best >= i_hq_level);
                        r_out.latest_product <= r_cmd.product_key;
                        r_out.entry_total    <= r_found_any ? w_tot : 7'(r_used + 1'b1);
                        if (!r_found_any) r_used <= r_used + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out   <= r_pend_data;
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_used_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_used <= CW'(TABLE_DEPTH);
    endproperty
    a_used_bound: assert property (p_used_bound) else $error("fill count overflow");
    property p_pop_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_q_pop |-> (r_state == S_IDLE);
    endproperty
    a_pop_idle: assert property (p_pop_idle) else $error("pop while busy");
    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n) (o_valid && i_stall) |=> $stable(o_data);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed under stall");
endmodule

### design/keyed_observation_aggregator.sv
// One command at a time: the engine pops a new command only when idle, and the table
// scan, one entry read at a time, sets the rate. Output stalls hold the engine back.
// Reset (synchronous, active low) empties the table and sets the level to 8500.
module keyed_observation_aggregator #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [13:0]    i_cfg_data,
    input  logic           i_valid,
    output logic           o_stall,
    input  koa_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output koa_pkg::t_out  o_data
);
    logic          r_hq_level;
    logic [13:0]   r_level;
    logic          w_q_valid;
    logic          w_q_pop;
    koa_pkg::t_in  w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= koa_pkg::HQ_LEVEL_RESET;
            r_hq_level <= 1'b0;
        end else if (i_cfg_we) begin
            r_level    <= i_cfg_data;
            r_hq_level <= 1'b1;
        end
    end

    koa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_data  (w_q_data)
    );

    koa_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hq_level (r_level),
        .i_q_valid  (w_q_valid),
        .o_q_pop    (w_q_pop),
        .i_q_data   (w_q_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    property p_cfg;
        @(posedge i_clk) disable iff (!i_rst_n) i_cfg_we |=> (r_level == $past(i_cfg_data));
    endproperty
    a_cfg: assert property (p_cfg) else $error("level write lost");
    property p_written;
        @(posedge i_clk) disable iff (!i_rst_n) i_cfg_we |=> r_hq_level;
    endproperty
    a_written: assert property (p_written) else $error("write mark missing");
    property p_reset_level;
        @(posedge i_clk) !i_rst_n |=> (r_level == koa_pkg::HQ_LEVEL_RESET) || !i_rst_n;
    endproperty
    a_reset_level: assert property (p_reset_level) else $error("level not reset");
endmodule
